// ===== src/cfar_pkg.sv =====
// ============================================================================
// cfar_pkg
// Shared types and constants of the cell-averaging peak detector
// ============================================================================
`default_nettype none
package cfar_pkg;
    localparam int CORDIC_STEPS = 20;
    localparam int ANG_W        = 24;
    localparam int CD_W         = 27;

    // config register indexes
    localparam logic [1:0] REG_ALPHA   = 2'd0;
    localparam logic [1:0] REG_SPAN    = 2'd1;
    localparam logic [1:0] REG_HOLDOFF = 2'd2;

    // arctangent table in units of pi/2^20
    function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        begin
            case (idx)
                5'd0: v = 24'd262144;
                5'd1: v = 24'd154753;
                5'd2: v = 24'd81767;
                5'd3: v = 24'd41506;
                5'd4: v = 24'd20834;
                5'd5: v = 24'd10427;
                5'd6: v = 24'd5215;
                5'd7: v = 24'd2608;
                5'd8: v = 24'd1304;
                5'd9: v = 24'd652;
                5'd10: v = 24'd326;
                5'd11: v = 24'd163;
                5'd12: v = 24'd81;
                5'd13: v = 24'd41;
                5'd14: v = 24'd20;
                5'd15: v = 24'd10;
                5'd16: v = 24'd5;
                5'd17: v = 24'd3;
                5'd18: v = 24'd1;
                5'd19: v = 24'd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // one result beat passed from the front part to the back part
    typedef struct packed {
        logic signed [15:0] sig_re;
        logic signed [15:0] sig_im;
        logic signed [15:0] corr_re;
        logic signed [15:0] corr_im;
        logic               detect;
        logic [4:0]         offset;
        logic signed [15:0] pk_re;
        logic signed [15:0] pk_im;
    } t_job;
endpackage
`default_nettype wire

// ===== src/cfar_front.sv =====
// ============================================================================
// cfar_front
// Window, magnitudes, noise sum, threshold test and peak search
// ============================================================================
`default_nettype none
module cfar_front #(
    parameter int TRAIN_CELLS = 16,
    parameter int GAP_CELLS   = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_sig_re,
    input  wire logic signed [15:0] i_sig_im,
    input  wire logic signed [15:0] i_corr_re,
    input  wire logic signed [15:0] i_corr_im,
    input  wire logic [15:0]        i_alpha,
    input  wire logic [4:0]         i_search_span,
    input  wire logic [15:0]        i_holdoff,
    output logic                    o_job_valid,
    input  wire logic               i_job_stall,
    output cfar_pkg::t_job          o_job
);
    localparam int DELAY = TRAIN_CELLS + GAP_CELLS;
    localparam int WIN   = 2 * DELAY + 1;
    localparam int SW    = $clog2(WIN + 2) + 16;
    localparam int WW    = $clog2(WIN + 2);
    localparam int CW    = $clog2(DELAY + 1);
    localparam int THR   = 2 * TRAIN_CELLS * 256;
    // cell leaving the newer training half, seen before the shift
    localparam int SUB_NEW = (TRAIN_CELLS + 2 * GAP_CELLS + 2 >= WIN) ? 1 : 0;
    localparam int SUB_IX  = (SUB_NEW != 0) ? WIN - 1 : TRAIN_CELLS + 2 * GAP_CELLS + 2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SQRT  = 5'b00010,
        ST_TEST  = 5'b00100,
        ST_SRCH  = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    logic signed [15:0] r_win_re [WIN];
    logic signed [15:0] r_win_im [WIN];
    logic [15:0]        r_mag [WIN];
    logic signed [15:0] r_dly_re [DELAY];
    logic signed [15:0] r_dly_im [DELAY];
    logic [SW-1:0]      r_sum, r_cur;
    logic [WW-1:0]      r_warm;
    logic [16:0]        r_hold;
    logic signed [15:0] r_osre, r_osim;
    logic [31:0]        r_rad, r_rem, r_root;
    logic [4:0]         r_sq_cnt;
    logic [CW-1:0]      r_idx, r_span;
    logic [4:0]         r_off;
    logic [31:0]        r_best;
    logic               r_fire;

    assign o_stall = (r_state != ST_IDLE);

    // restoring square root, one result bit a cycle
    logic [33:0] w_trial;
    logic [31:0] w_rem_sh;
    assign w_rem_sh = {r_rem[29:0], r_rad[31:30]};
    assign w_trial  = {2'b0, w_rem_sh} - {r_root[29:0], 2'b01};

    // magnitude finished on the last root step
    logic [15:0] w_new_mag, w_sub_mag;
    assign w_new_mag = {r_root[14:0], ~w_trial[33]};
    assign w_sub_mag = (SUB_NEW != 0) ? w_new_mag : r_mag[SUB_IX];

    // power of the search cell
    logic signed [15:0] w_sre, w_sim;
    logic [31:0] w_pw;
    assign w_sre = r_win_re[DELAY + 32'(r_idx)];
    assign w_sim = r_win_im[DELAY + 32'(r_idx)];
    assign w_pw  = 32'(w_sre * w_sre) + 32'(w_sim * w_sim);

    logic [31:0] w_lhs;
    logic [SW+15:0] w_rhs;
    assign w_lhs = 32'(r_mag[DELAY]) * 32'(THR);
    assign w_rhs = (SW+16)'(i_alpha) * (SW+16)'(r_cur);

    // holdoff load, counted down once on the detecting beat
    logic [16:0] w_hold_sum;
    assign w_hold_sum = 17'(r_off) + 17'(i_holdoff);

    logic [CW-1:0] w_span;
    always_comb begin
        if (i_search_span == 5'd0) w_span = CW'(1);
        else if (32'(i_search_span) > DELAY) w_span = CW'(DELAY);
        else w_span = CW'(i_search_span);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            o_job_valid <= 1'b0;
            r_sum       <= '0;
            r_warm      <= WW'(WIN);
            r_hold      <= '0;
            for (int k = 0; k < WIN; k++) begin
                r_win_re[k] <= '0;
                r_win_im[k] <= '0;
                r_mag[k]    <= '0;
            end
            for (int k = 0; k < DELAY; k++) begin
                r_dly_re[k] <= '0;
                r_dly_im[k] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_osre <= r_dly_re[0];
                        r_osim <= r_dly_im[0];
                        for (int k = 0; k < DELAY - 1; k++) begin
                            r_dly_re[k] <= r_dly_re[k+1];
                            r_dly_im[k] <= r_dly_im[k+1];
                        end
                        r_dly_re[DELAY-1] <= i_sig_re;
                        r_dly_im[DELAY-1] <= i_sig_im;
                        for (int k = 0; k < WIN - 1; k++) begin
                            r_win_re[k] <= r_win_re[k+1];
                            r_win_im[k] <= r_win_im[k+1];
                        end
                        r_win_re[WIN-1] <= i_corr_re;
                        r_win_im[WIN-1] <= i_corr_im;
                        r_rad    <= 32'(i_corr_re * i_corr_re) + 32'(i_corr_im * i_corr_im);
                        r_rem    <= '0;
                        r_root   <= '0;
                        r_sq_cnt <= '0;
                        r_state  <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_rad <= {r_rad[29:0], 2'b00};
                    if (!w_trial[33]) begin
                        r_rem  <= w_trial[31:0];
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_sq_cnt <= r_sq_cnt + 5'd1;
                    if (r_sq_cnt == 5'd15) begin
                        // shift magnitude window and update the sum
                        for (int k = 0; k < WIN - 1; k++) r_mag[k] <= r_mag[k+1];
                        r_mag[WIN-1] <= w_new_mag;
                        r_cur <= r_sum + SW'(r_mag[TRAIN_CELLS]) + SW'(w_new_mag);
                        r_sum <= r_sum + SW'(r_mag[TRAIN_CELLS]) + SW'(w_new_mag)
                               - SW'(r_mag[1]) - SW'(w_sub_mag);
                        r_state <= ST_TEST;
                    end
                end
                ST_TEST: begin
                    r_off  <= '0;
                    r_idx  <= CW'(1);
                    r_span <= w_span;
                    r_best <= 32'(r_win_re[DELAY] * r_win_re[DELAY])
                            + 32'(r_win_im[DELAY] * r_win_im[DELAY]);
                    r_fire <= (r_warm == '0) && (r_hold == '0) &&
                              ((SW+16)'(w_lhs) > w_rhs);
                    if ((r_warm == '0) && (r_hold == '0) && ((SW+16)'(w_lhs) > w_rhs))
                        r_state <= ST_SRCH;
                    else begin
                        if (r_hold != '0) r_hold <= r_hold - 17'd1;
                        if (r_warm != '0) r_warm <= r_warm - WW'(1);
                        r_state <= ST_OUT;
                    end
                end
                ST_SRCH: begin
                    if (r_idx >= r_span) begin
                        r_hold <= (w_hold_sum == '0) ? '0 : w_hold_sum - 17'd1;
                        if (r_warm != '0) r_warm <= r_warm - WW'(1);
                        r_state <= ST_OUT;
                    end else begin
                        if (w_pw > r_best) begin
                            r_best <= w_pw;
                            r_off  <= 5'(r_idx);
                        end
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_OUT: begin
                    if (!o_job_valid || !i_job_stall) begin
                        o_job_valid    <= 1'b1;
                        o_job.sig_re   <= r_osre;
                        o_job.sig_im   <= r_osim;
                        o_job.corr_re  <= r_win_re[DELAY];
                        o_job.corr_im  <= r_win_im[DELAY];
                        o_job.detect   <= r_fire;
                        o_job.offset   <= r_fire ? r_off : 5'd0;
                        o_job.pk_re    <= r_win_re[DELAY + 32'(r_off)];
                        o_job.pk_im    <= r_win_im[DELAY + 32'(r_off)];
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (o_job_valid && !i_job_stall && r_state != ST_OUT) o_job_valid <= 1'b0;
        end
    end

    property p_span_ok;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH) |-> (r_span >= CW'(1));
    endproperty
    a_span_ok: assert property (p_span_ok) else $error("bad span");

    property p_off_in_span;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH) |-> (32'(r_off) < DELAY);
    endproperty
    a_off_in_span: assert property (p_off_in_span) else $error("offset range");

    property p_no_fire_warm;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TEST && r_warm != '0) |=> !r_fire;
    endproperty
    a_no_fire_warm: assert property (p_no_fire_warm) else $error("fire in warmup");
endmodule
`default_nettype wire

// ===== src/cfar_back.sv =====
// ============================================================================
// cfar_back
// Queue of result beats and iterative CORDIC phase of the peak
// ============================================================================
`default_nettype none
module cfar_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_valid,
    output logic                    o_job_stall,
    input  wire cfar_pkg::t_job     i_job,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_out_sig_re,
    output logic signed [15:0]      o_out_sig_im,
    output logic signed [15:0]      o_out_corr_re,
    output logic signed [15:0]      o_out_corr_im,
    output logic                    o_detect,
    output logic [4:0]              o_peak_offset,
    output logic signed [15:0]      o_peak_phase
);
    localparam int AW = cfar_pkg::ANG_W;
    localparam int XW = cfar_pkg::CD_W;

    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_ROT  = 3'b010,
        BS_OUT  = 3'b100
    } t_bstate;

    // two-entry queue
    cfar_pkg::t_job r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    t_bstate        r_st;
    cfar_pkg::t_job r_job;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic [4:0]           r_i;
    logic                 r_zero;

    assign o_job_stall = (r_cnt == 2'd2);
    logic w_push, w_pop;
    assign w_push = i_job_valid && !o_job_stall;
    assign w_pop  = (r_st == BS_IDLE) && (r_cnt != 2'd0);

    // truncating shifts toward zero
    logic signed [XW-1:0] w_sy, w_sx, w_ay, w_ax;
    assign w_ay = (r_y < 0) ? -r_y : r_y;
    assign w_ax = r_x;
    assign w_sy = (r_y < 0) ? -(w_ay >>> r_i) : (w_ay >>> r_i);
    assign w_sx = w_ax >>> r_i;

    logic signed [AW+1:0] w_q;
    logic signed [AW+1:0] w_nz;
    assign w_nz = -(AW+2)'(r_z) + (AW+2)'(26'sd4194304) + (AW+2)'(26'sd16);
    assign w_q  = (w_nz >>> 5) - (AW+2)'(26'sd131072);

    logic signed [XW-1:0] w_ix, w_iy;
    assign w_ix = XW'(r_q[r_rp].pk_re) <<< 8;
    assign w_iy = XW'(r_q[r_rp].pk_im) <<< 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
            r_st <= BS_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= i_job;
                r_wp <= ~r_wp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
            if (o_valid && !i_stall && r_st != BS_OUT) o_valid <= 1'b0;
            unique case (r_st)
                BS_IDLE: begin
                    if (w_pop) begin
                        r_job  <= r_q[r_rp];
                        r_rp   <= ~r_rp;
                        r_i    <= '0;
                        r_zero <= (r_q[r_rp].pk_re == 0) && (r_q[r_rp].pk_im == 0);
                        if (w_ix < 0) begin
                            r_z <= (w_iy >= 0) ? AW'(24'sd1048576) : -AW'(24'sd1048576);
                            r_x <= -w_ix;
                            r_y <= -w_iy;
                        end else begin
                            r_z <= '0;
                            r_x <= w_ix;
                            r_y <= w_iy;
                        end
                        r_st <= r_q[r_rp].detect ? BS_ROT : BS_OUT;
                    end
                end
                BS_ROT: begin
                    if (r_y > 0) begin
                        r_x <= r_x + w_sy;
                        r_y <= r_y - w_sx;
                        r_z <= r_z + AW'(cfar_pkg::atan_lut(r_i));
                    end else if (r_y < 0) begin
                        r_x <= r_x - w_sy;
                        r_y <= r_y + w_sx;
                        r_z <= r_z - AW'(cfar_pkg::atan_lut(r_i));
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(cfar_pkg::CORDIC_STEPS - 1)) r_st <= BS_OUT;
                end
                BS_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid       <= 1'b1;
                        o_out_sig_re  <= r_job.sig_re;
                        o_out_sig_im  <= r_job.sig_im;
                        o_out_corr_re <= r_job.corr_re;
                        o_out_corr_im <= r_job.corr_im;
                        o_detect      <= r_job.detect;
                        o_peak_offset <= r_job.offset;
                        if (!r_job.detect || r_zero) o_peak_phase <= '0;
                        else if (w_q > 32767) o_peak_phase <= 16'sh7fff;
                        else if (w_q < -32768) o_peak_phase <= 16'sh8000;
                        else o_peak_phase <= w_q[15:0];
                        r_st <= BS_IDLE;
                    end
                end
                default: r_st <= BS_IDLE;
            endcase
        end
    end

    property p_cnt_max;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2;
    endproperty
    a_cnt_max: assert property (p_cnt_max) else $error("queue overflow");

    property p_rot_len;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_st == BS_ROT) |-> (r_i < 5'(cfar_pkg::CORDIC_STEPS));
    endproperty
    a_rot_len: assert property (p_rot_len) else $error("cordic overrun");

    property p_nodet_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_detect) |-> (o_peak_phase == 0 && o_peak_offset == 0);
    endproperty
    a_nodet_zero: assert property (p_nodet_zero) else $error("phase without detect");
endmodule
`default_nettype wire

// ===== src/ca_cfar_peak_detector.sv =====
// a beat passes the input window, the 16-step bit-serial magnitude square root, the
//   threshold test, the peak search on a detect and the result register of the front
//   part, which takes no new beat until the last is handed on to the back part
// the CORDIC phase (20 steps) runs in the back part behind a two-entry queue
// synchronous active-low reset clears window, sums and counters; config to defaults
// ============================================================================
// ca_cfar_peak_detector
// Cell-averaging threshold detector with peak offset and phase
// ============================================================================
`default_nettype none
module ca_cfar_peak_detector #(
    parameter int TRAIN_CELLS = 16,
    parameter int GAP_CELLS   = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_sig_re,
    input  wire logic signed [15:0] i_sig_im,
    input  wire logic signed [15:0] i_corr_re,
    input  wire logic signed [15:0] i_corr_im,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_out_sig_re,
    output logic signed [15:0]      o_out_sig_im,
    output logic signed [15:0]      o_out_corr_re,
    output logic signed [15:0]      o_out_corr_im,
    output logic                    o_detect,
    output logic [4:0]              o_peak_offset,
    output logic signed [15:0]      o_peak_phase,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data
);
    logic [15:0] r_alpha, r_holdoff;
    logic [4:0]  r_span;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= 16'd1974;
            r_span    <= 5'd8;
            r_holdoff <= 16'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cfar_pkg::REG_ALPHA:   r_alpha   <= i_cfg_data;
                cfar_pkg::REG_SPAN:    r_span    <= i_cfg_data[4:0];
                cfar_pkg::REG_HOLDOFF: r_holdoff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic           w_jv, w_js;
    cfar_pkg::t_job w_job;

    cfar_front #(.TRAIN_CELLS(TRAIN_CELLS), .GAP_CELLS(GAP_CELLS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_sig_re, .i_sig_im, .i_corr_re, .i_corr_im,
        .i_alpha(r_alpha), .i_search_span(r_span), .i_holdoff(r_holdoff),
        .o_job_valid(w_jv), .i_job_stall(w_js), .o_job(w_job)
    );

    cfar_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_jv), .o_job_stall(w_js), .i_job(w_job),
        .o_valid, .i_stall, .o_out_sig_re, .o_out_sig_im, .o_out_corr_re,
        .o_out_corr_im, .o_detect, .o_peak_offset, .o_peak_phase
    );
endmodule
`default_nettype wire

// ===== tb/tb_ca_cfar_peak_detector.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_ca_cfar_peak_detector
// Self-checking bench: a behavioral predictor of the threshold detector runs
// beside the block, every result beat is compared field by field
// ============================================================================
module tb_ca_cfar_peak_detector;
    localparam int TRAIN = 16;
    localparam int GAP   = 4;
    localparam int LAG   = TRAIN + GAP;
    localparam int WLEN  = 2 * LAG + 1;

    typedef struct {
        logic signed [15:0] sig_re;
        logic signed [15:0] sig_im;
        logic signed [15:0] corr_re;
        logic signed [15:0] corr_im;
        logic               detect;
        logic [4:0]         offset;
        logic signed [15:0] phase;
    } t_cfar_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_sig_re, i_sig_im, i_corr_re, i_corr_im;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_out_sig_re, o_out_sig_im, o_out_corr_re, o_out_corr_im;
    logic               o_detect;
    logic [4:0]         o_peak_offset;
    logic signed [15:0] o_peak_phase;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;

    // shadow state of the detector
    int          cell_re [WLEN];
    int          cell_im [WLEN];
    int          cell_mag[WLEN];
    int          lag_re  [LAG];
    int          lag_im  [LAG];
    int          noise_acc;
    int          warm_cnt;
    int          hold_cnt;
    int          thr_alpha;
    int          span_cfg;
    int          hold_cfg;

    t_cfar_beat  expected_beats[$];
    int          fail_cnt;
    int          idle_pct;
    int          stall_pct;

    ca_cfar_peak_detector #(.TRAIN_CELLS(TRAIN), .GAP_CELLS(GAP)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_sig_re(i_sig_re), .i_sig_im(i_sig_im),
        .i_corr_re(i_corr_re), .i_corr_im(i_corr_im),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_sig_re(o_out_sig_re), .o_out_sig_im(o_out_sig_im),
        .o_out_corr_re(o_out_corr_re), .o_out_corr_im(o_out_corr_im),
        .o_detect(o_detect), .o_peak_offset(o_peak_offset),
        .o_peak_phase(o_peak_phase),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("tb_ca_cfar_peak_detector: FAIL");
        $finish;
    end

    // integer square root, restoring method
    function automatic longint floor_sqrt(input longint v);
        longint root, rem, trial;
        begin
            root = 0;
            rem  = 0;
            for (int b = 31; b >= 0; b--) begin
                rem   = (rem << 2) | ((v >> (2 * b)) & 3);
                trial = (root << 2) | 1;
                root  = root << 1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = root | 1;
                end
            end
            return root;
        end
    endfunction

    // shift right with truncation toward zero
    function automatic longint shift_trunc(input longint v, input int s);
        begin
            return (v < 0) ? -((-v) >>> s) : (v >>> s);
        end
    endfunction

    // negated angle of (re, im), 32768 = pi, via vectoring rotations
    function automatic int neg_angle(input int re, input int im);
        longint x, y, z, t, q;
        begin
            if (re == 0 && im == 0) return 0;
            x = longint'(re) * 256;
            y = longint'(im) * 256;
            z = 0;
            if (x < 0) begin
                z = (y >= 0) ? (longint'(1) << 20) : -(longint'(1) << 20);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < cfar_pkg::CORDIC_STEPS; i++) begin
                t = x;
                if (y > 0) begin
                    x = x + shift_trunc(y, i);
                    y = y - shift_trunc(t, i);
                    z = z + longint'(cfar_pkg::atan_lut(5'(i)));
                end else if (y < 0) begin
                    x = x - shift_trunc(y, i);
                    y = y + shift_trunc(t, i);
                    z = z - longint'(cfar_pkg::atan_lut(5'(i)));
                end
            end
            q = ((-z + (longint'(1) << 22) + 16) >>> 5) - (longint'(1) << 17);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return int'(q);
        end
    endfunction

    // advance the shadow detector by one sample and queue its result
    task automatic predict_cfar_beat(input int sre, input int sim, input int cre,
                                     input int cim);
        t_cfar_beat r;
        int         cur, span, off;
        longint     best, pw;
        begin
            r.sig_re = 16'(lag_re[0]);
            r.sig_im = 16'(lag_im[0]);
            for (int i = 0; i < LAG - 1; i++) begin
                lag_re[i] = lag_re[i+1];
                lag_im[i] = lag_im[i+1];
            end
            lag_re[LAG-1] = sre;
            lag_im[LAG-1] = sim;
            for (int i = 0; i < WLEN - 1; i++) begin
                cell_re[i]  = cell_re[i+1];
                cell_im[i]  = cell_im[i+1];
                cell_mag[i] = cell_mag[i+1];
            end
            cell_re[WLEN-1]  = cre;
            cell_im[WLEN-1]  = cim;
            cell_mag[WLEN-1] = int'(floor_sqrt(longint'(cre) * cre + longint'(cim) * cim));
            noise_acc = noise_acc + cell_mag[TRAIN-1] + cell_mag[WLEN-1];
            cur = noise_acc;
            noise_acc = noise_acc - cell_mag[0] - cell_mag[TRAIN + 2 * GAP + 1];
            off = 0;
            r.detect = 1'b0;
            r.phase  = '0;
            if (warm_cnt == 0 && hold_cnt == 0 &&
                longint'(cell_mag[LAG]) * (2 * TRAIN * 256) >
                longint'(thr_alpha) * cur) begin
                span = (span_cfg < 1) ? 1 : (span_cfg > LAG) ? LAG : span_cfg;
                best = longint'(cell_re[LAG]) * cell_re[LAG] +
                       longint'(cell_im[LAG]) * cell_im[LAG];
                for (int i = 1; i < span; i++) begin
                    pw = longint'(cell_re[LAG+i]) * cell_re[LAG+i] +
                         longint'(cell_im[LAG+i]) * cell_im[LAG+i];
                    if (pw > best) begin
                        best = pw;
                        off  = i;
                    end
                end
                r.detect = 1'b1;
                r.phase  = 16'(neg_angle(cell_re[LAG+off], cell_im[LAG+off]));
                hold_cnt = off + hold_cfg;
            end
            if (hold_cnt > 0) hold_cnt--;
            if (warm_cnt > 0) warm_cnt--;
            r.corr_re = 16'(cell_re[LAG]);
            r.corr_im = 16'(cell_im[LAG]);
            r.offset  = 5'(off);
            expected_beats.push_back(r);
        end
    endtask

    // send one sample beat, at times with a random idle gap in front
    task automatic send_sample(input logic signed [15:0] sre, input logic signed [15:0] sim,
                               input logic signed [15:0] cre, input logic signed [15:0] cim);
        bit taken;
        begin
            if ($urandom_range(0, 99) < idle_pct) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_valid   <= 1'b1;
            i_sig_re  <= sre;
            i_sig_im  <= sim;
            i_corr_re <= cre;
            i_corr_im <= cim;
            do begin
                @(negedge i_clk);
                taken = !o_stall;
                if (taken) predict_cfar_beat(sre, sim, cre, cim);
                @(posedge i_clk);
            end while (!taken);
        end
    endtask

    // stop sending and let every outstanding result drain
    task automatic drain_results();
        begin
            i_valid <= 1'b0;
            while (expected_beats.size() > 0) @(posedge i_clk);
            repeat (80) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= 16'(value);
            @(posedge i_clk);
            case (idx)
                cfar_pkg::REG_ALPHA:   thr_alpha = value & 16'hFFFF;
                cfar_pkg::REG_SPAN:    span_cfg  = value & 5'h1F;
                cfar_pkg::REG_HOLDOFF: hold_cfg  = value & 16'hFFFF;
                default: ;
            endcase
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic set_config(input int alpha_v, input int span_v, input int hold_v);
        begin
            write_reg(cfar_pkg::REG_ALPHA, alpha_v);
            write_reg(cfar_pkg::REG_SPAN, span_v);
            write_reg(cfar_pkg::REG_HOLDOFF, hold_v);
        end
    endtask

    function automatic logic signed [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // extremes of every field, tied peaks, span limits
    task automatic test_directed();
        begin
            idle_pct  = 0;
            stall_pct = 0;
            set_config(0, 0, 0);
            send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
            send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000);
            send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
            send_sample(16'shFFFF, 16'sh0001, 16'sh8000, 16'sh7FFF);
            send_sample(16'sh5555, 16'shAAAA, 16'sh0000, 16'sh8000);
            for (int i = 0; i < 10; i++)
                send_sample(rnd16(), rnd16(), 16'(i), 16'(-i));
            drain_results();
            set_config(0, 31, 0);
            // tied peaks in adjacent cells, then opposite quadrants
            send_sample(16'sh1234, 16'sh4321, 16'sh8000, 16'sh0000);
            send_sample(16'sh0001, 16'shFFFF, 16'sh8000, 16'sh0000);
            send_sample(rnd16(), rnd16(), 16'sh0000, 16'sh7FFF);
            send_sample(rnd16(), rnd16(), 16'sh8001, 16'sh8001);
            send_sample(rnd16(), rnd16(), 16'sh7FFF, 16'sh8001);
            for (int i = 0; i < 5; i++)
                send_sample(rnd16(), rnd16(), 16'sh0000, 16'sh0000);
            drain_results();
        end
    endtask

    // noise floor with sparse spikes, plus some fully random samples
    task automatic test_spike_bursts(input int n_items, input int i_pct, input int s_pct);
        int floor_amp, left, amp;
        logic signed [15:0] pk_re, pk_im;
        begin
            idle_pct  = i_pct;
            stall_pct = s_pct;
            left      = 0;
            floor_amp = $urandom_range(1, 400);
            for (int n = 0; n < n_items; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_sample(rnd16(), rnd16(), rnd16(), rnd16());
                end else if (left > 0) begin
                    // repeated spike makes ties, otherwise a fresh one
                    if ($urandom_range(0, 2) != 0) begin
                        amp   = $urandom_range(floor_amp * 4, 32767);
                        pk_re = 16'(16'($urandom_range(0, amp)) *
                                    ($urandom_range(0, 1) ? 1 : -1));
                        pk_im = 16'(16'($urandom_range(0, amp)) *
                                    ($urandom_range(0, 1) ? 1 : -1));
                    end
                    send_sample(rnd16(), rnd16(), pk_re, pk_im);
                    left--;
                end else begin
                    if ($urandom_range(0, 24) == 0) begin
                        left  = $urandom_range(1, 4);
                        pk_re = 16'sh0;
                        pk_im = 16'sh0;
                    end
                    send_sample(rnd16(), rnd16(),
                                16'($signed($urandom_range(0, 2 * floor_amp)) - floor_amp),
                                16'($signed($urandom_range(0, 2 * floor_amp)) - floor_amp));
                end
            end
            drain_results();
        end
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // result checker: a beat is taken at the next edge when valid and not stalled
    task automatic check_field(input string name, input int exp_v, input int act_v);
        begin
            if (exp_v != act_v) begin
                fail_cnt++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                         act_v);
            end
        end
    endtask

    always @(negedge i_clk) begin
        t_cfar_beat e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_beats.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected result beat, expected none, actual detect=%0d",
                         $time, o_detect);
            end else begin
                e = expected_beats.pop_front();
                check_field("out_sig_re", e.sig_re, o_out_sig_re);
                check_field("out_sig_im", e.sig_im, o_out_sig_im);
                check_field("out_corr_re", e.corr_re, o_out_corr_re);
                check_field("out_corr_im", e.corr_im, o_out_corr_im);
                check_field("detect", e.detect, o_detect);
                check_field("peak_offset", e.offset, o_peak_offset);
                check_field("peak_phase", e.phase, o_peak_phase);
            end
        end
    end

    // main sequence
    initial begin
        fail_cnt   = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        noise_acc  = 0;
        warm_cnt   = WLEN;
        hold_cnt   = 0;
        thr_alpha  = 1974;
        span_cfg   = 8;
        hold_cfg   = 64;
        for (int i = 0; i < WLEN; i++) begin
            cell_re[i]  = 0;
            cell_im[i]  = 0;
            cell_mag[i] = 0;
        end
        for (int i = 0; i < LAG; i++) begin
            lag_re[i] = 0;
            lag_im[i] = 0;
        end
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_stall    <= 1'b0;
        i_sig_re   <= '0;
        i_sig_im   <= '0;
        i_corr_re  <= '0;
        i_corr_im  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the registers first
        test_spike_bursts(350, 0, 0);
        test_directed();
        set_config(65535, 20, 65535);
        test_spike_bursts(150, 49, 0);
        set_config(1974, 1, 0);
        test_spike_bursts(250, 0, 49);
        set_config($urandom_range(0, 65535), $urandom_range(0, 31), $urandom_range(0, 300));
        test_spike_bursts(250, 28, 28);
        set_config($urandom_range(300, 3000), 21, 16);
        test_spike_bursts(250, 0, 0);
        set_config($urandom_range(0, 65535), $urandom_range(0, 31), $urandom_range(0, 65535));
        test_spike_bursts(150, 49, 0);
        set_config($urandom_range(500, 2500), $urandom_range(0, 31), $urandom_range(0, 40));
        test_spike_bursts(250, 28, 28);
        drain_results();

        if (fail_cnt == 0)
            $display("tb_ca_cfar_peak_detector: PASS");
        else
            $display("tb_ca_cfar_peak_detector: FAIL");
        $finish;
    end
endmodule
